### src/rv32im_subset_execute_core_defines.svh
// Assertion macros of the checker file of the execute core.
`ifndef RV32IM_SUBSET_EXECUTE_CORE_DEFINES_SVH
`define RV32IM_SUBSET_EXECUTE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define RV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define RV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/rv32ex_pkg.sv
// Shared constants and types of the RV32IM subset execute core.
package rv32ex_pkg;

	localparam int unsigned MEM_BYTES_DEF = 65536;

	// Major opcodes.
	localparam logic [6:0] OP_R     = 7'h33;
	localparam logic [6:0] OP_LOAD  = 7'h03;
	localparam logic [6:0] OP_IMM   = 7'h13;
	localparam logic [6:0] OP_SYS   = 7'h73;
	localparam logic [6:0] OP_STORE = 7'h23;
	localparam logic [6:0] OP_BR    = 7'h63;
	localparam logic [6:0] OP_LUI   = 7'h37;
	localparam logic [6:0] OP_JAL   = 7'h6f;

	// funct7 groups.
	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_ALT    = 7'h20;
	localparam logic [6:0] F7_MULDIV = 7'h01;

	// funct3 codes that the sequencer tests by name.
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;
	localparam logic [2:0] F3_MUL  = 3'd0;
	localparam logic [2:0] F3_MULH = 3'd1;
	localparam logic [2:0] F3_DIV  = 3'd4;
	localparam logic [2:0] F3_REM  = 3'd6;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BYTE = 3'd0;
	localparam logic [2:0] F3_HALF = 3'd1;
	localparam logic [2:0] F3_WORD = 3'd2;

	// Environment call.
	localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
	localparam logic [31:0] SVC_PRINT  = 32'd1;
	localparam logic [31:0] SVC_EXIT   = 32'd10;
	localparam logic [4:0]  REG_A0     = 5'd10;
	localparam logic [4:0]  REG_A1     = 5'd11;

	// Command codes of an input beat.
	localparam logic CMD_EXEC    = 1'b0;
	localparam logic CMD_PRELOAD = 1'b1;

	typedef enum logic [1:0] {
		FLT_NONE    = 2'd0,
		FLT_ILLEGAL = 2'd1,
		FLT_ECALL   = 2'd2,
		FLT_RANGE   = 2'd3
	} fault_t;

endpackage

### src/rv32ex_if.sv
// Valid/ready channel interfaces of the execute core.
interface rv32ex_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport mon (input valid, input data, input ready);
endinterface

interface rv32ex_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] instr_word;
	logic [15:0] preload_addr;
	logic [7:0]  preload_byte;
	modport source (output valid, output cmd, output instr_word, output preload_addr,
		output preload_byte, input ready);
	modport sink (input valid, input cmd, input instr_word, input preload_addr,
		input preload_byte, output ready);
	modport mon (input valid, input cmd, input instr_word, input preload_addr,
		input preload_byte, input ready);
endinterface

interface rv32ex_out_if;
	logic               valid;
	logic               ready;
	logic        [31:0] next_pc;
	logic               print_valid;
	logic signed [31:0] print_value;
	logic               halted;
	logic        [1:0]  fault_code;
	modport source (output valid, output next_pc, output print_valid, output print_value,
		output halted, output fault_code, input ready);
	modport sink (input valid, input next_pc, input print_valid, input print_value,
		input halted, input fault_code, output ready);
	modport mon (input valid, input next_pc, input print_valid, input print_value,
		input halted, input fault_code, input ready);
endinterface

### src/rv32im_subset_execute_core.sv
// RV32IM subset execute core: sequencer, register file, data memory and shared unit.
//
// Channel  Dir  Carries
// cfg      in   data: start PC, loaded into the PC at once
// in_ch    in   cmd, instr_word, preload_addr, preload_byte
// out_ch   out  next_pc, print_valid, print_value, halted, fault_code
//
// A preload or a halted item goes straight to the finish step; a plain instruction takes two
// register file reads, one execute step and finish; a load or store adds memory steps, one byte
// per cycle through the single data memory port plus a final step for the last registered read
// byte; mul, mulh, div and rem add iterations on the shared adder and a sign fix step, except a
// division by zero, which adds none. in_ch is ready only while the sequencer is idle; a result
// waits in the output register, and a finished item stalls in its last step only while that
// register is still full. arst_n clears the PC, halt flag, register file valid bits and all handshake state.
module rv32im_subset_execute_core #(
	parameter int unsigned MEM_BYTES = rv32ex_pkg::MEM_BYTES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	rv32ex_cfg_if.sink   cfg,
	rv32ex_in_if.sink    in_ch,
	rv32ex_out_if.source out_ch
);

	localparam int unsigned AW = $clog2(MEM_BYTES);
	localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RDA  = 8'b0000_0010,
		S_RDB  = 8'b0000_0100,
		S_EXEC = 8'b0000_1000,
		S_ITER = 8'b0001_0000,
		S_FIX  = 8'b0010_0000,
		S_MEM  = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic        [31:0] instr_q, a_q, b_q, pc_q, npc_q, res_q, addr_q, dv_q, ld_q;
	logic        [32:0] hi_q;
	logic        [31:0] lo_q;
	logic        [4:0]  iter_q;
	logic        [2:0]  cnt_q, nbytes_q;
	logic               halt_q, wr_q, commit_q, stop_q, pv_q, neg_q, is_div_q, is_store_q;
	rv32ex_pkg::fault_t fault_q;

	// Output register.
	logic               ovld_q, opv_q, ohalt_q;
	logic        [31:0] onpc_q;
	logic signed [31:0] opval_q;
	logic        [1:0]  ofault_q;

	// Register file: one read port with registered data, valid bits give the zero reset.
	logic [31:0] rf_mem [32];
	logic [31:0] rf_vld_q;
	logic [31:0] rf_rdat_q;
	logic        rf_rvld_q;
	logic [4:0]  rf_raddr;
	logic [31:0] rf_val;
	logic        rf_we;

	// Data memory: one port, registered read.
	logic [7:0]    dmem [MEM_BYTES];
	logic [7:0]    dmem_rdat_q;
	logic [AW-1:0] dmem_addr;
	logic          dmem_we;
	logic [7:0]    dmem_wdat;

	logic in_fire, out_free;
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign cfg.ready   = 1'b1;
	assign out_free    = !ovld_q || out_ch.ready;

	assign out_ch.valid       = ovld_q;
	assign out_ch.next_pc     = onpc_q;
	assign out_ch.print_valid = opv_q;
	assign out_ch.print_value = opval_q;
	assign out_ch.halted      = ohalt_q;
	assign out_ch.fault_code  = ofault_q;

	// Decode fields of the held instruction.
	logic [6:0]  op, f7;
	logic [2:0]  f3;
	logic [4:0]  rd;
	logic [31:0] imm_i, imm_s, imm_b, imm_j, opb, alu_res, pc4, ls_addr;
	logic [32:0] ls_end;
	logic        alt, r_legal, i_legal;
	assign op    = instr_q[6:0];
	assign rd    = instr_q[11:7];
	assign f3    = instr_q[14:12];
	assign f7    = instr_q[31:25];
	assign imm_i = {{20{instr_q[31]}}, instr_q[31:20]};
	assign imm_s = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
	assign imm_b = {{19{instr_q[31]}}, instr_q[31], instr_q[7], instr_q[30:25],
		instr_q[11:8], 1'b0};
	assign imm_j = {{11{instr_q[31]}}, instr_q[31], instr_q[19:12], instr_q[20],
		instr_q[30:21], 1'b0};
	assign alt   = (f7 == rv32ex_pkg::F7_ALT);
	assign opb   = (op == rv32ex_pkg::OP_R) ? b_q : imm_i;
	assign pc4   = pc_q + 32'd4;
	assign ls_addr = a_q + ((op == rv32ex_pkg::OP_STORE) ? imm_s : imm_i);
	assign ls_end  = {1'b0, ls_addr} + (33'd1 << f3[1:0]);

	// Legal encodings of the register and immediate ALU forms.
	always_comb begin
		r_legal = 1'b0;
		case (f7)
			rv32ex_pkg::F7_BASE:   r_legal = (f3 != 3'd3);
			rv32ex_pkg::F7_ALT:    r_legal = (f3 == rv32ex_pkg::F3_ADD) ||
				(f3 == rv32ex_pkg::F3_SR);
			rv32ex_pkg::F7_MULDIV: r_legal = (f3 == rv32ex_pkg::F3_MUL) ||
				(f3 == rv32ex_pkg::F3_MULH) || (f3 == rv32ex_pkg::F3_DIV) ||
				(f3 == rv32ex_pkg::F3_REM);
			default:               r_legal = 1'b0;
		endcase
		case (f3)
			rv32ex_pkg::F3_SLL: i_legal = (f7 == rv32ex_pkg::F7_BASE);
			rv32ex_pkg::F3_SR:  i_legal = (f7 == rv32ex_pkg::F7_BASE) || alt;
			3'd3:               i_legal = 1'b0;
			default:            i_legal = 1'b1;
		endcase
	end

	// Combinational ALU for the base operations.
	always_comb begin
		case (f3)
			rv32ex_pkg::F3_ADD: alu_res = (alt && op == rv32ex_pkg::OP_R) ? a_q - opb : a_q + opb;
			rv32ex_pkg::F3_SLL: alu_res = a_q << opb[4:0];
			rv32ex_pkg::F3_SLT: alu_res = {31'd0, $signed(a_q) < $signed(opb)};
			rv32ex_pkg::F3_XOR: alu_res = a_q ^ opb;
			rv32ex_pkg::F3_SR:  alu_res = alt ? 32'($signed(a_q) >>> opb[4:0]) : a_q >> opb[4:0];
			rv32ex_pkg::F3_OR:  alu_res = a_q | opb;
			rv32ex_pkg::F3_AND: alu_res = a_q & opb;
			default:            alu_res = 32'd0;
		endcase
	end

	// Shared adder of the multiply and divide iterations.
	logic [32:0] div_shift;
	logic [33:0] add_x, add_y, add_sum;
	logic        add_cin;
	assign div_shift = {hi_q[31:0], lo_q[31]};
	always_comb begin
		if (is_div_q) begin
			add_x   = {1'b0, div_shift};
			add_y   = ~{2'b00, dv_q};
			add_cin = 1'b1;
		end else begin
			add_x   = {1'b0, hi_q};
			add_y   = lo_q[0] ? {2'b00, dv_q} : 34'd0;
			add_cin = 1'b0;
		end
		add_sum = add_x + add_y + {33'd0, add_cin};
	end

	// Sign fix of the product, quotient and remainder.
	logic [63:0] prod, prod_fix;
	logic [31:0] qr, qr_fix, fix_res;
	assign prod     = {hi_q[31:0], lo_q};
	assign prod_fix = neg_q ? 64'd0 - prod : prod;
	assign qr       = (f3 == rv32ex_pkg::F3_DIV) ? lo_q : hi_q[31:0];
	assign qr_fix   = neg_q ? 32'd0 - qr : qr;
	always_comb begin
		if (!is_div_q) begin
			fix_res = (f3 == rv32ex_pkg::F3_MUL) ? prod_fix[31:0] : prod_fix[63:32];
		end else begin
			fix_res = qr_fix;
		end
	end

	// Assembled load value.
	logic [31:0] ld_res;
	always_comb begin
		case (f3)
			rv32ex_pkg::F3_BYTE: ld_res = {{24{ld_q[7]}}, ld_q[7:0]};
			rv32ex_pkg::F3_HALF: ld_res = {{16{ld_q[15]}}, ld_q[15:0]};
			default:             ld_res = ld_q;
		endcase
	end

	// Register file read address and port.
	always_comb begin
		if (state_q == S_IDLE) begin
			rf_raddr = (in_ch.instr_word[6:0] == rv32ex_pkg::OP_SYS) ? rv32ex_pkg::REG_A0 :
				in_ch.instr_word[19:15];
		end else begin
			rf_raddr = (op == rv32ex_pkg::OP_SYS) ? rv32ex_pkg::REG_A1 : instr_q[24:20];
		end
	end
	assign rf_val = rf_rvld_q ? rf_rdat_q : 32'd0;
	assign rf_we  = (state_q == S_FIN) && out_free && commit_q && wr_q && (rd != 5'd0);

	always_ff @(posedge clk) begin
		rf_rdat_q <= rf_mem[rf_raddr];
		if (rf_we) begin
			rf_mem[rd] <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q  <= 32'd0;
			rf_rvld_q <= 1'b0;
		end else begin
			rf_rvld_q <= rf_vld_q[rf_raddr];
			if (rf_we) begin
				rf_vld_q[rd] <= 1'b1;
			end
		end
	end

	// Data memory port: preload in idle, byte steps of loads and stores otherwise.
	logic [2:0] lane;
	assign lane = cnt_q - 3'd1;
	always_comb begin
		if (state_q == S_IDLE) begin
			dmem_addr = AW'(in_ch.preload_addr);
			dmem_wdat = in_ch.preload_byte;
			dmem_we   = in_fire && (in_ch.cmd == rv32ex_pkg::CMD_PRELOAD) &&
				({16'd0, in_ch.preload_addr} < 32'(MEM_BYTES));
		end else begin
			dmem_addr = AW'(addr_q + {29'd0, cnt_q});
			dmem_wdat = b_q[{cnt_q[1:0], 3'b000} +: 8];
			dmem_we   = (state_q == S_MEM) && is_store_q && (cnt_q < nbytes_q);
		end
	end

	always_ff @(posedge clk) begin
		dmem_rdat_q <= dmem[dmem_addr];
		if (dmem_we) begin
			dmem[dmem_addr] <= dmem_wdat;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= 32'd0;
			halt_q  <= 1'b0;
			ovld_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				pc_q <= cfg.data;
			end
			// The finish step reloads the output register itself.
			if (ovld_q && out_ch.ready && state_q != S_FIN) begin
				ovld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						instr_q  <= in_ch.instr_word;
						commit_q <= 1'b0;
						wr_q     <= 1'b0;
						stop_q   <= 1'b0;
						pv_q     <= 1'b0;
						fault_q  <= rv32ex_pkg::FLT_NONE;
						if (in_ch.cmd == rv32ex_pkg::CMD_PRELOAD || halt_q) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_RDA;
						end
					end
				end
				S_RDA: begin
					a_q     <= rf_val;
					state_q <= S_RDB;
				end
				S_RDB: begin
					b_q     <= rf_val;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					npc_q   <= pc4;
					state_q <= S_FIN;
					case (op)
						rv32ex_pkg::OP_R, rv32ex_pkg::OP_IMM: begin
							if ((op == rv32ex_pkg::OP_R) ? !r_legal : !i_legal) begin
								fault_q <= rv32ex_pkg::FLT_ILLEGAL;
							end else if (op == rv32ex_pkg::OP_R && f7 == rv32ex_pkg::F7_MULDIV) begin
								commit_q <= 1'b1;
								wr_q     <= 1'b1;
								is_div_q <= f3[2];
								iter_q   <= 5'd0;
								hi_q     <= 33'd0;
								if (!f3[2]) begin
									dv_q    <= a_q[31] ? 32'd0 - a_q : a_q;
									lo_q    <= b_q[31] ? 32'd0 - b_q : b_q;
									neg_q   <= a_q[31] ^ b_q[31];
									state_q <= S_ITER;
								end else if (b_q == 32'd0) begin
									res_q <= (f3 == rv32ex_pkg::F3_DIV) ? 32'hFFFF_FFFF : a_q;
								end else begin
									dv_q    <= b_q[31] ? 32'd0 - b_q : b_q;
									lo_q    <= a_q[31] ? 32'd0 - a_q : a_q;
									neg_q   <= (f3 == rv32ex_pkg::F3_DIV) ? a_q[31] ^ b_q[31] : a_q[31];
									state_q <= S_ITER;
								end
							end else begin
								commit_q <= 1'b1;
								wr_q     <= 1'b1;
								res_q    <= alu_res;
							end
						end
						rv32ex_pkg::OP_LOAD, rv32ex_pkg::OP_STORE: begin
							if (f3 > rv32ex_pkg::F3_WORD) begin
								fault_q <= rv32ex_pkg::FLT_ILLEGAL;
							end else if (ls_end > MEM_LIMIT) begin
								fault_q <= rv32ex_pkg::FLT_RANGE;
							end else begin
								commit_q   <= 1'b1;
								wr_q       <= (op == rv32ex_pkg::OP_LOAD);
								is_store_q <= (op == rv32ex_pkg::OP_STORE);
								addr_q     <= ls_addr;
								nbytes_q   <= 3'd1 << f3[1:0];
								cnt_q      <= 3'd0;
								state_q    <= S_MEM;
							end
						end
						rv32ex_pkg::OP_BR: begin
							if (f3 != rv32ex_pkg::F3_BEQ && f3 != rv32ex_pkg::F3_BNE) begin
								fault_q <= rv32ex_pkg::FLT_ILLEGAL;
							end else begin
								commit_q <= 1'b1;
								if ((a_q == b_q) == (f3 == rv32ex_pkg::F3_BEQ)) begin
									npc_q <= pc_q + imm_b;
								end
							end
						end
						rv32ex_pkg::OP_LUI: begin
							commit_q <= 1'b1;
							wr_q     <= 1'b1;
							res_q    <= {instr_q[31:12], 12'd0};
						end
						rv32ex_pkg::OP_JAL: begin
							commit_q <= 1'b1;
							wr_q     <= 1'b1;
							res_q    <= pc4;
							npc_q    <= pc_q + imm_j;
						end
						rv32ex_pkg::OP_SYS: begin
							// a_q holds a0 and b_q holds a1 for an environment call.
							if (instr_q != rv32ex_pkg::ECALL_WORD) begin
								fault_q <= rv32ex_pkg::FLT_ILLEGAL;
							end else if (a_q == rv32ex_pkg::SVC_PRINT) begin
								commit_q <= 1'b1;
								pv_q     <= 1'b1;
							end else if (a_q == rv32ex_pkg::SVC_EXIT) begin
								stop_q <= 1'b1;
							end else begin
								fault_q <= rv32ex_pkg::FLT_ECALL;
							end
						end
						default: begin
							fault_q <= rv32ex_pkg::FLT_ILLEGAL;
						end
					endcase
				end
				S_ITER: begin
					iter_q <= iter_q + 5'd1;
					if (is_div_q) begin
						if (!add_sum[33]) begin
							hi_q <= add_sum[32:0];
							lo_q <= {lo_q[30:0], 1'b1};
						end else begin
							hi_q <= div_shift;
							lo_q <= {lo_q[30:0], 1'b0};
						end
					end else begin
						hi_q <= {1'b0, add_sum[32:1]};
						lo_q <= {add_sum[0], lo_q[31:1]};
					end
					if (iter_q == 5'd31) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					res_q   <= fix_res;
					state_q <= S_FIN;
				end
				S_MEM: begin
					// Read bytes arrive in the cycle after their address.
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q != 3'd0 && cnt_q <= nbytes_q) begin
						ld_q[{lane[1:0], 3'b000} +: 8] <= dmem_rdat_q;
					end
					if (cnt_q == nbytes_q + 3'd1) begin
						res_q   <= ld_res;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						ovld_q   <= 1'b1;
						onpc_q   <= commit_q ? npc_q : pc_q;
						opv_q    <= pv_q;
						opval_q  <= pv_q ? $signed(b_q) : 32'sd0;
						ohalt_q  <= halt_q || stop_q || (fault_q != rv32ex_pkg::FLT_NONE);
						ofault_q <= fault_q;
						if (commit_q) begin
							pc_q <= npc_q;
						end
						if (stop_q || fault_q != rv32ex_pkg::FLT_NONE) begin
							halt_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### src/rv32ex_checker.sv
// Port-level checker of the execute core and its bind.
`include "rv32im_subset_execute_core_defines.svh"

module rv32ex_checker (
	input logic          clk,
	input logic          arst_n,
	rv32ex_in_if.sink    in_ch,
	rv32ex_out_if.source out_ch
);

	// A faulting result always reports the machine halted.
	`RV_ASSERT_NOW(a_fault_halts, out_ch.valid && out_ch.fault_code != 2'd0, out_ch.halted,
		"fault reported without halt")

	// A print result carries no fault and does not halt.
	`RV_ASSERT_NOW(a_print_clean, out_ch.valid && out_ch.print_valid,
		out_ch.fault_code == 2'd0 && !out_ch.halted, "print result with fault or halt")

	// An accepted item keeps the input closed for at least the next cycle.
	`RV_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready,
		"input ready right after an accepted beat")

	// A stalled result beat holds its next_pc and halted fields.
	`RV_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(out_ch.next_pc) && $stable(out_ch.halted),
		"stalled result beat changed")

endmodule

bind rv32im_subset_execute_core rv32ex_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.in_ch  (in_ch),
	.out_ch (out_ch)
);

### tb/sv/rv32im_subset_execute_core_test.sv
// Self-checking testbench of the RV32IM subset execute core.
`timescale 1ns / 1ps

module rv32im_subset_execute_core_test;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AT_BEAT   = 400;
	localparam int RANDOM_ITEMS   = 240;

	typedef struct {
		logic [31:0]        next_pc;
		logic               pv;
		logic [31:0]        pval;
		logic               halted;
		rv32ex_pkg::fault_t fault;
	} retire_t;

	typedef struct {
		logic        cmd;
		logic [31:0] word;
		logic [15:0] addr;
		logic [7:0]  bval;
		bit          typed;
		retire_t     res;
	} dir_row_t;

	logic clk;
	logic arst_n;

	rv32ex_cfg_if cfg_bus ();
	rv32ex_in_if  in_bus ();
	rv32ex_out_if out_bus ();

	rv32im_subset_execute_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.in_ch  (in_bus),
		.out_ch (out_bus)
	);

	// Architectural state of the machine as the testbench sees it.
	logic [31:0] arch_reg [32];
	logic [31:0] arch_pc;
	logic [7:0]  arch_mem [rv32ex_pkg::MEM_BYTES_DEF];
	bit          mem_written [rv32ex_pkg::MEM_BYTES_DEF];
	bit          arch_halt;

	retire_t  retire_q [$];
	dir_row_t dir_tab [$];
	int       errors;
	int       in_beats;
	int       out_beats;
	int       print_beats;
	int       cfg_writes;
	bit       quiet;
	bit       held;
	int       hold_left;
	int       stall_cnt;

	// Instruction encoders.
	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd,
		logic [4:0] rs1, logic [4:0] rs2);
		return {f7, rs2, rs1, f3, rd, rv32ex_pkg::OP_R};
	endfunction

	function automatic logic [31:0] enc_i(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
		logic [4:0] rs1, logic [11:0] imm);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
		logic [11:0] imm);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], rv32ex_pkg::OP_STORE};
	endfunction

	function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
		logic [12:0] o);
		return {o[12], o[10:5], rs2, rs1, f3, o[4:1], o[11], rv32ex_pkg::OP_BR};
	endfunction

	function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] o);
		return {o[20], o[10:1], o[11], o[19:12], rd, rv32ex_pkg::OP_JAL};
	endfunction

	function automatic logic [31:0] enc_u(logic [4:0] rd, logic [19:0] v);
		return {v, rd, rv32ex_pkg::OP_LUI};
	endfunction

	// A plain result: the given PC, no print, running, no fault.
	function automatic retire_t exp_r(logic [31:0] pc);
		retire_t r;
		r.next_pc = pc;
		r.pv = 1'b0;
		r.pval = '0;
		r.halted = 1'b0;
		r.fault = rv32ex_pkg::FLT_NONE;
		return r;
	endfunction

	// True when all n bytes at addr lie in memory and have been written.
	function automatic bit mem_ok(logic [31:0] addr, int n);
		if ({32'd0, addr} + n > rv32ex_pkg::MEM_BYTES_DEF)
			return 0;
		for (int i = 0; i < n; i++)
			if (!mem_written[addr[15:0] + i])
				return 0;
		return 1;
	endfunction

	// Retires one beat against the architectural state and returns its result.
	function automatic retire_t retire(logic cmd, logic [31:0] w, logic [15:0] pa,
		logic [7:0] pb);
		retire_t r;
		logic [6:0] op;
		logic [6:0] f7;
		logic [2:0] f3;
		logic [4:0] rd;
		logic [31:0] a, b, res, npc, addr, si, ssi;
		longint sa, sb;
		logic signed [63:0] prod;
		logic [12:0] boff;
		logic [20:0] joff;
		bit wr_en, stop, take;
		rv32ex_pkg::fault_t flt;
		int n;
		flt = rv32ex_pkg::FLT_NONE;
		stop = 0;
		r.pv = 0;
		r.pval = '0;
		if (cmd == rv32ex_pkg::CMD_PRELOAD) begin
			arch_mem[pa] = pb;
			mem_written[pa] = 1;
		end else if (!arch_halt) begin
			op = w[6:0];
			rd = w[11:7];
			f3 = w[14:12];
			f7 = w[31:25];
			a = arch_reg[w[19:15]];
			b = arch_reg[w[24:20]];
			sa = longint'($signed(a));
			sb = longint'($signed(b));
			si = {{20{w[31]}}, w[31:20]};
			ssi = {{20{w[31]}}, w[31:25], w[11:7]};
			npc = arch_pc + 32'd4;
			res = '0;
			wr_en = 0;
			case (op)
				rv32ex_pkg::OP_R: begin
					wr_en = 1;
					case (f7)
						rv32ex_pkg::F7_BASE: begin
							case (f3)
								rv32ex_pkg::F3_ADD: res = a + b;
								rv32ex_pkg::F3_SLL: res = a << b[4:0];
								rv32ex_pkg::F3_SLT: res = {31'd0, $signed(a) < $signed(b)};
								rv32ex_pkg::F3_XOR: res = a ^ b;
								rv32ex_pkg::F3_SR:  res = a >> b[4:0];
								rv32ex_pkg::F3_OR:  res = a | b;
								rv32ex_pkg::F3_AND: res = a & b;
								default: flt = rv32ex_pkg::FLT_ILLEGAL;
							endcase
						end
						rv32ex_pkg::F7_ALT: begin
							if (f3 == rv32ex_pkg::F3_ADD)
								res = a - b;
							else if (f3 == rv32ex_pkg::F3_SR)
								res = $signed(a) >>> b[4:0];
							else
								flt = rv32ex_pkg::FLT_ILLEGAL;
						end
						rv32ex_pkg::F7_MULDIV: begin
							case (f3)
								rv32ex_pkg::F3_MUL: res = a * b;
								rv32ex_pkg::F3_MULH: begin
									prod = sa * sb;
									res = prod[63:32];
								end
								rv32ex_pkg::F3_DIV:
									res = (b == 0) ? 32'hFFFF_FFFF : 32'(sa / sb);
								rv32ex_pkg::F3_REM:
									res = (b == 0) ? a : 32'(sa % sb);
								default: flt = rv32ex_pkg::FLT_ILLEGAL;
							endcase
						end
						default: flt = rv32ex_pkg::FLT_ILLEGAL;
					endcase
				end
				rv32ex_pkg::OP_IMM: begin
					wr_en = 1;
					case (f3)
						rv32ex_pkg::F3_ADD: res = a + si;
						rv32ex_pkg::F3_SLL: begin
							if (f7 != rv32ex_pkg::F7_BASE)
								flt = rv32ex_pkg::FLT_ILLEGAL;
							else
								res = a << w[24:20];
						end
						rv32ex_pkg::F3_SLT: res = {31'd0, $signed(a) < $signed(si)};
						rv32ex_pkg::F3_XOR: res = a ^ si;
						rv32ex_pkg::F3_SR: begin
							if (f7 == rv32ex_pkg::F7_BASE)
								res = a >> w[24:20];
							else if (f7 == rv32ex_pkg::F7_ALT)
								res = $signed(a) >>> w[24:20];
							else
								flt = rv32ex_pkg::FLT_ILLEGAL;
						end
						rv32ex_pkg::F3_OR:  res = a | si;
						rv32ex_pkg::F3_AND: res = a & si;
						default: flt = rv32ex_pkg::FLT_ILLEGAL;
					endcase
				end
				rv32ex_pkg::OP_LOAD: begin
					addr = a + si;
					wr_en = 1;
					if (f3 > rv32ex_pkg::F3_WORD) begin
						flt = rv32ex_pkg::FLT_ILLEGAL;
					end else begin
						n = 1 << f3;
						if ({32'd0, addr} + n > rv32ex_pkg::MEM_BYTES_DEF) begin
							flt = rv32ex_pkg::FLT_RANGE;
						end else begin
							for (int i = n - 1; i >= 0; i--)
								res = (res << 8) | arch_mem[addr[15:0] + i];
							if (n == 1)
								res = {{24{res[7]}}, res[7:0]};
							else if (n == 2)
								res = {{16{res[15]}}, res[15:0]};
						end
					end
				end
				rv32ex_pkg::OP_STORE: begin
					addr = a + ssi;
					if (f3 > rv32ex_pkg::F3_WORD) begin
						flt = rv32ex_pkg::FLT_ILLEGAL;
					end else begin
						n = 1 << f3;
						if ({32'd0, addr} + n > rv32ex_pkg::MEM_BYTES_DEF) begin
							flt = rv32ex_pkg::FLT_RANGE;
						end else begin
							for (int i = 0; i < n; i++) begin
								arch_mem[addr[15:0] + i] = b[8 * i +: 8];
								mem_written[addr[15:0] + i] = 1;
							end
						end
					end
				end
				rv32ex_pkg::OP_BR: begin
					boff = {w[31], w[7], w[30:25], w[11:8], 1'b0};
					take = 0;
					if (f3 == rv32ex_pkg::F3_BEQ)
						take = (a == b);
					else if (f3 == rv32ex_pkg::F3_BNE)
						take = (a != b);
					else
						flt = rv32ex_pkg::FLT_ILLEGAL;
					if (take)
						npc = arch_pc + {{19{boff[12]}}, boff};
				end
				rv32ex_pkg::OP_LUI: begin
					res = {w[31:12], 12'd0};
					wr_en = 1;
				end
				rv32ex_pkg::OP_JAL: begin
					joff = {w[31], w[19:12], w[20], w[30:21], 1'b0};
					res = arch_pc + 32'd4;
					wr_en = 1;
					npc = arch_pc + {{11{joff[20]}}, joff};
				end
				rv32ex_pkg::OP_SYS: begin
					if (w != rv32ex_pkg::ECALL_WORD)
						flt = rv32ex_pkg::FLT_ILLEGAL;
					else if (arch_reg[rv32ex_pkg::REG_A0] == rv32ex_pkg::SVC_PRINT) begin
						r.pv = 1;
						r.pval = arch_reg[rv32ex_pkg::REG_A1];
					end else if (arch_reg[rv32ex_pkg::REG_A0] == rv32ex_pkg::SVC_EXIT)
						stop = 1;
					else
						flt = rv32ex_pkg::FLT_ECALL;
				end
				default: flt = rv32ex_pkg::FLT_ILLEGAL;
			endcase
			// A fault or an exit freezes the machine without any write.
			if (flt != rv32ex_pkg::FLT_NONE || stop) begin
				arch_halt = 1;
				r.pv = 0;
				r.pval = '0;
			end else begin
				if (wr_en && rd != 0)
					arch_reg[rd] = res;
				arch_pc = npc;
			end
		end
		r.next_pc = arch_pc;
		r.halted = arch_halt;
		r.fault = flt;
		return r;
	endfunction

	// Offers one input beat after a random gap and records its expected result.
	task automatic send_beat(logic cmd, logic [31:0] w, logic [15:0] pa, logic [7:0] pb,
		bit typed, retire_t tr);
		int gap;
		retire_t r;
		gap = 0;
		if (!quiet)
			while ($urandom_range(99) < 34)
				gap++;
		if (gap > 0) begin
			in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.cmd <= cmd;
		in_bus.instr_word <= w;
		in_bus.preload_addr <= pa;
		in_bus.preload_byte <= pb;
		@(posedge clk);
		while (!in_bus.ready)
			@(posedge clk);
		r = retire(cmd, w, pa, pb);
		retire_q.push_back(typed ? tr : r);
		in_beats++;
	endtask

	task automatic send_exec(logic [31:0] w);
		send_beat(rv32ex_pkg::CMD_EXEC, w, 16'($urandom), 8'($urandom), 0, exp_r(32'd0));
	endtask

	task automatic send_preload();
		send_beat(rv32ex_pkg::CMD_PRELOAD, $urandom, 16'($urandom), 8'($urandom), 0,
			exp_r(32'd0));
	endtask

	// Writes the start PC once every result is back and the core has gone quiet.
	task automatic write_start_pc(logic [31:0] v);
		in_bus.valid <= 1'b0;
		while (retire_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= v;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cfg_bus.valid <= 1'b0;
		arch_pc = v;
		cfg_writes++;
	endtask

	// Sends one random preload or one random instruction that keeps the machine running.
	task automatic random_beat();
		int k, n;
		logic [2:0] f3;
		logic [4:0] rs1;
		logic [11:0] imm;
		logic [31:0] w;
		k = $urandom_range(99);
		if (k < 10) begin
			send_preload();
			return;
		end
		w = $urandom;
		if (k < 35) begin
			n = $urandom_range(12);
			if (n < 7)
				w = enc_r(rv32ex_pkg::F7_BASE, (n < 3) ? 3'(n) : 3'(n + 1), w[11:7], w[19:15],
					w[24:20]);
			else if (n == 7)
				w = enc_r(rv32ex_pkg::F7_ALT, rv32ex_pkg::F3_ADD, w[11:7], w[19:15], w[24:20]);
			else if (n == 8)
				w = enc_r(rv32ex_pkg::F7_ALT, rv32ex_pkg::F3_SR, w[11:7], w[19:15], w[24:20]);
			else if (n == 9)
				w = enc_r(rv32ex_pkg::F7_MULDIV, rv32ex_pkg::F3_MUL, w[11:7], w[19:15],
					w[24:20]);
			else if (n == 10)
				w = enc_r(rv32ex_pkg::F7_MULDIV, rv32ex_pkg::F3_MULH, w[11:7], w[19:15],
					w[24:20]);
			else if (n == 11)
				w = enc_r(rv32ex_pkg::F7_MULDIV, rv32ex_pkg::F3_DIV, w[11:7], w[19:15],
					w[24:20]);
			else
				w = enc_r(rv32ex_pkg::F7_MULDIV, rv32ex_pkg::F3_REM, w[11:7], w[19:15],
					w[24:20]);
		end else if (k < 55) begin
			n = $urandom_range(6);
			f3 = (n < 3) ? 3'(n) : 3'(n + 1);
			imm = w[31:20];
			if (f3 == rv32ex_pkg::F3_SLL)
				imm[11:5] = rv32ex_pkg::F7_BASE;
			else if (f3 == rv32ex_pkg::F3_SR)
				imm[11:5] = $urandom_range(1) ? rv32ex_pkg::F7_ALT : rv32ex_pkg::F7_BASE;
			w = enc_i(rv32ex_pkg::OP_IMM, f3, w[11:7], w[19:15], imm);
		end else if (k < 65) begin
			// Loads only touch bytes that hold known data.
			f3 = 3'($urandom_range(2));
			n = 1 << f3;
			rs1 = w[19:15];
			imm = w[31:20];
			for (int t = 0; t < 16 && !mem_ok(arch_reg[rs1] + {{20{imm[11]}}, imm}, n);
				t++) begin
				rs1 = 5'd0;
				imm = 12'($urandom_range(2047));
			end
			if (!mem_ok(arch_reg[rs1] + {{20{imm[11]}}, imm}, n)) begin
				rs1 = 5'd0;
				imm = '0;
			end
			w = enc_i(rv32ex_pkg::OP_LOAD, f3, w[11:7], rs1, imm);
		end else if (k < 75) begin
			f3 = 3'($urandom_range(2));
			n = 1 << f3;
			rs1 = w[19:15];
			imm = {w[31:25], w[11:7]};
			if ({32'd0, arch_reg[rs1] + {{20{imm[11]}}, imm}} + n >
				rv32ex_pkg::MEM_BYTES_DEF) begin
				rs1 = 5'd0;
				imm = 12'($urandom_range(2044));
			end
			w = enc_s(f3, rs1, w[24:20], imm);
		end else if (k < 83) begin
			w = enc_b($urandom_range(1) ? rv32ex_pkg::F3_BNE : rv32ex_pkg::F3_BEQ, w[19:15],
				w[24:20], {w[31:20], 1'b0});
		end else if (k < 88) begin
			w = enc_j(w[11:7], {w[31:12], 1'b0});
		end else if (k < 93) begin
			w = enc_u(w[11:7], w[31:12]);
		end else if (k < 97 && arch_reg[rv32ex_pkg::REG_A0] == rv32ex_pkg::SVC_PRINT) begin
			w = rv32ex_pkg::ECALL_WORD;
		end else begin
			w = enc_i(rv32ex_pkg::OP_IMM, rv32ex_pkg::F3_ADD, rv32ex_pkg::REG_A0, 5'd0,
				12'(rv32ex_pkg::SVC_PRINT));
		end
		send_exec(w);
	endtask

	// One directed row whose result is typed in.
	task automatic add_typed(logic cmd, logic [31:0] w, logic [15:0] pa, logic [7:0] pb,
		logic [31:0] pc);
		dir_tab.push_back('{cmd, w, pa, pb, 1'b1, exp_r(pc)});
	endtask

	// One directed instruction checked against the predictor.
	task automatic add_exec(logic [31:0] w);
		dir_tab.push_back('{rv32ex_pkg::CMD_EXEC, w, 16'd0, 8'd0, 1'b0, exp_r(32'd0)});
	endtask

	// Directed rows: extremes, corner cases of the arithmetic, and every beat kind.
	task automatic build_directed();
		add_typed(rv32ex_pkg::CMD_EXEC, enc_u(5'd1, 20'hFFFFF), 16'd0, 8'd0, 32'd4);
		add_typed(rv32ex_pkg::CMD_EXEC, enc_i(rv32ex_pkg::OP_IMM, rv32ex_pkg::F3_ADD, 5'd2,
			5'd0, 12'h800), 16'd0, 8'd0, 32'd8);
		add_typed(rv32ex_pkg::CMD_EXEC, enc_i(rv32ex_pkg::OP_IMM, rv32ex_pkg::F3_ADD, 5'd3,
			5'd0, 12'h7FF), 16'd0, 8'd0, 32'd12);
		add_typed(rv32ex_pkg::CMD_PRELOAD, 32'd0, 16'hFFFF, 8'hFF, 32'd12);
		add_typed(rv32ex_pkg::CMD_PRELOAD, 32'd0, 16'h0000, 8'h80, 32'd12);
		add_typed(rv32ex_pkg::CMD_PRELOAD, 32'd0, 16'h0001, 8'h7F, 32'd12);
		add_typed(rv32ex_pkg::CMD_PRELOAD, 32'd0, 16'h0002, 8'h01, 32'd12);
		add_typed(rv32ex_pkg::CMD_PRELOAD, 32'd0, 16'h0003, 8'hFE, 32'd12);
		add_exec(enc_i(rv32ex_pkg::OP_LOAD, rv32ex_pkg::F3_BYTE, 5'd4, 5'd0, 12'd0));
		add_exec(enc_i(rv32ex_pkg::OP_LOAD, rv32ex_pkg::F3_HALF, 5'd5, 5'd0, 12'd0));
		add_exec(enc_i(rv32ex_pkg::OP_LOAD, rv32ex_pkg::F3_WORD, 5'd6, 5'd0, 12'd0));
		// Top byte of memory, reached through a base register.
		add_exec(enc_u(5'd7, 20'h00010));
		add_exec(enc_i(rv32ex_pkg::OP_LOAD, rv32ex_pkg::F3_BYTE, 5'd8, 5'd7, 12'hFFF));
		add_exec(enc_r(rv32ex_pkg::F7_MULDIV, rv32ex_pkg::F3_MULH, 5'd9, 5'd1, 5'd2));
		// Division and remainder by zero.
		add_exec(enc_r(rv32ex_pkg::F7_MULDIV, rv32ex_pkg::F3_DIV, 5'd12, 5'd1, 5'd0));
		add_exec(enc_r(rv32ex_pkg::F7_MULDIV, rv32ex_pkg::F3_REM, 5'd13, 5'd1, 5'd0));
		// Signed overflow: most negative value divided by minus one.
		add_exec(enc_u(5'd14, 20'h80000));
		add_exec(enc_i(rv32ex_pkg::OP_IMM, rv32ex_pkg::F3_ADD, 5'd15, 5'd0, 12'hFFF));
		add_exec(enc_r(rv32ex_pkg::F7_MULDIV, rv32ex_pkg::F3_DIV, 5'd16, 5'd14, 5'd15));
		add_exec(enc_r(rv32ex_pkg::F7_MULDIV, rv32ex_pkg::F3_REM, 5'd17, 5'd14, 5'd15));
		// Shift amounts come from the low five bits only.
		add_exec(enc_r(rv32ex_pkg::F7_BASE, rv32ex_pkg::F3_SLL, 5'd18, 5'd1, 5'd3));
		add_exec(enc_r(rv32ex_pkg::F7_ALT, rv32ex_pkg::F3_SR, 5'd19, 5'd14, 5'd3));
		add_exec(enc_i(rv32ex_pkg::OP_IMM, rv32ex_pkg::F3_SR, 5'd20, 5'd14,
			{rv32ex_pkg::F7_ALT, 5'd31}));
		// A write to x0 is dropped.
		add_exec(enc_i(rv32ex_pkg::OP_IMM, rv32ex_pkg::F3_ADD, 5'd0, 5'd3, 12'd5));
		add_exec(enc_s(rv32ex_pkg::F3_WORD, 5'd0, 5'd0, 12'd8));
		add_exec(enc_j(5'd0, -21'sd4));
		add_exec(enc_j(5'd21, 21'd8));
		add_exec(enc_b(rv32ex_pkg::F3_BEQ, 5'd0, 5'd0, -13'sd8));
		add_exec(enc_b(rv32ex_pkg::F3_BNE, 5'd0, 5'd0, 13'd16));
		// Print service with the most negative value.
		add_exec(enc_i(rv32ex_pkg::OP_IMM, rv32ex_pkg::F3_ADD, rv32ex_pkg::REG_A0, 5'd0,
			12'(rv32ex_pkg::SVC_PRINT)));
		add_exec(enc_r(rv32ex_pkg::F7_BASE, rv32ex_pkg::F3_ADD, rv32ex_pkg::REG_A1, 5'd14,
			5'd0));
		add_exec(rv32ex_pkg::ECALL_WORD);
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side: random stalls, a quiet stretch, and one long hold-off.
	initial begin
		out_bus.ready = 1'b0;
		held = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_bus.ready <= 1'b0;
			end else if (!held && out_beats >= HOLD_AT_BEAT) begin
				held = 1;
				hold_left = HOLD_CYCLES;
				out_bus.ready <= 1'b0;
			end else begin
				out_bus.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 34);
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && out_bus.valid && out_bus.ready) begin
			out_beats++;
			if (retire_q.size() == 0) begin
				$error("result beat with no expected result, next_pc %h", out_bus.next_pc);
				errors++;
			end else begin
				retire_t e;
				e = retire_q.pop_front();
				if (out_bus.next_pc !== e.next_pc) begin
					$error("next_pc expected %h actual %h", e.next_pc, out_bus.next_pc);
					errors++;
				end
				if (out_bus.print_valid !== e.pv) begin
					$error("print_valid expected %0d actual %0d", e.pv, out_bus.print_valid);
					errors++;
				end
				if (out_bus.print_value !== e.pval) begin
					$error("print_value expected %h actual %h", e.pval, out_bus.print_value);
					errors++;
				end
				if (out_bus.halted !== e.halted) begin
					$error("halted expected %0d actual %0d", e.halted, out_bus.halted);
					errors++;
				end
				if (out_bus.fault_code !== e.fault) begin
					$error("fault_code expected %0d actual %0d", e.fault, out_bus.fault_code);
					errors++;
				end
				if (e.pv)
					print_beats++;
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready))
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= WATCHDOG_LIMIT) begin
				$display("rv32im_subset_execute_core_test failed");
				$finish;
			end
		end
	end

	// Stimulus.
	initial begin
		int kind;
		errors = 0;
		in_beats = 0;
		out_beats = 0;
		print_beats = 0;
		cfg_writes = 0;
		stall_cnt = 0;
		quiet = 0;
		arst_n = 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.data <= '0;
		in_bus.valid <= 1'b0;
		in_bus.cmd <= rv32ex_pkg::CMD_EXEC;
		in_bus.instr_word <= '0;
		in_bus.preload_addr <= '0;
		in_bus.preload_byte <= '0;
		for (int i = 0; i < 32; i++)
			arch_reg[i] = '0;
		arch_pc = '0;
		arch_halt = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_start_pc(32'd0);
		build_directed();
		foreach (dir_tab[i])
			send_beat(dir_tab[i].cmd, dir_tab[i].word, dir_tab[i].addr, dir_tab[i].bval,
				dir_tab[i].typed, dir_tab[i].res);

		// Random phases under different start PCs, the middle one without idling.
		write_start_pc(32'hFFFF_FFFF);
		repeat (RANDOM_ITEMS) random_beat();
		write_start_pc($urandom);
		quiet = 1;
		repeat (RANDOM_ITEMS) random_beat();
		quiet = 0;
		write_start_pc(32'hFFFF_FFFC);
		repeat (RANDOM_ITEMS) random_beat();

		// One terminal event, then beats that meet a halted machine.
		kind = $urandom_range(3);
		case (kind)
			0: send_exec($urandom | 32'h0000_007F);
			1: begin
				send_exec(enc_i(rv32ex_pkg::OP_IMM, rv32ex_pkg::F3_ADD, rv32ex_pkg::REG_A0,
					5'd0, 12'd2));
				send_exec(rv32ex_pkg::ECALL_WORD);
			end
			2: send_exec(enc_i(rv32ex_pkg::OP_LOAD, rv32ex_pkg::F3_WORD, 5'd1, 5'd0, 12'hFFC));
			default: begin
				send_exec(enc_i(rv32ex_pkg::OP_IMM, rv32ex_pkg::F3_ADD, rv32ex_pkg::REG_A0,
					5'd0, 12'(rv32ex_pkg::SVC_EXIT)));
				send_exec(rv32ex_pkg::ECALL_WORD);
			end
		endcase
		repeat (3) send_exec($urandom);
		send_preload();
		in_bus.valid <= 1'b0;

		while (retire_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		$display("Ran %0d beats with %0d results, %0d prints and %0d start PC writes.",
			in_beats, out_beats, print_beats, cfg_writes);
		$display("The run ended with terminal event kind %0d and a long result hold-off.",
			kind);
		if (errors == 0) begin
			$display("rv32im_subset_execute_core_test passed");
		end else begin
			$display("rv32im_subset_execute_core_test failed");
		end
		$finish;
	end

endmodule
